FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define CCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("ccd check failed");

// clocked assertion that also holds through reset
`define CCD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ccd reset check failed");

`endif

FILE: rtl/core/ccd_pkg.sv
package ccd_pkg;

  localparam int GRID_POINTS   = 64;
  localparam int FRACTION_BITS = 16;
  localparam int IDX_W         = $clog2(GRID_POINTS);

  localparam int POS_W    = 32;
  localparam int SCALE_W  = 24;
  localparam int WEIGHT_W = 32;
  localparam int DENS_W   = 48;
  localparam int PROD_W   = POS_W + SCALE_W;
  localparam int SPLIT_W  = WEIGHT_W + FRACTION_BITS;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int OUT_FIELDS_W = IDX_W + DENS_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SCALE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEPOSIT_WEIGHT = CFG_IDX_W'(1);

  localparam logic [SCALE_W-1:0]  CELL_SCALE_RST     = SCALE_W'(65536);
  localparam logic [WEIGHT_W-1:0] DEPOSIT_WEIGHT_RST = WEIGHT_W'(65536);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DENS_W-1:0] dens_t;

  // one deposit, broadcast to every cell
  typedef struct packed {
    logic                vld;
    logic                last;
    idx_t                left_idx;
    idx_t                right_idx;
    logic [WEIGHT_W-1:0] left_amt;
    logic [WEIGHT_W-1:0] right_amt;
  } dep_t;

endpackage

FILE: rtl/core/ccd_scale.sv
module ccd_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [ccd_pkg::POS_W-1:0]     in_pos,
  input  logic                          in_last,
  input  logic [ccd_pkg::SCALE_W-1:0]   cell_scale,
  input  logic [ccd_pkg::WEIGHT_W-1:0]  deposit_weight,
  output ccd_pkg::dep_t                 dep
);
  import ccd_pkg::*;

  // stage a: position times scale
  logic              vld_a_r, last_a_r;
  logic [PROD_W-1:0] prod_a_r;
  // stage b: weight split by fraction
  logic                vld_b_r, last_b_r;
  idx_t                idx_b_r;
  logic [WEIGHT_W-1:0] right_b_r;
  // stage c: deposit register
  dep_t dep_r;

  logic [PROD_W:0]         prod_full;
  logic [FRACTION_BITS-1:0] frac;
  logic [SPLIT_W-1:0]       split;

  assign prod_full = $signed(in_pos) * $signed({1'b0, cell_scale});
  assign frac      = prod_a_r[POS_W-1 -: FRACTION_BITS];
  assign split     = deposit_weight * frac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r   <= 1'b0;
      vld_b_r   <= 1'b0;
      dep_r.vld <= 1'b0;
    end else begin
      vld_a_r   <= in_vld;
      vld_b_r   <= vld_a_r;
      dep_r.vld <= vld_b_r;
    end
    prod_a_r        <= prod_full[PROD_W-1:0];
    last_a_r        <= in_last;
    idx_b_r         <= prod_a_r[POS_W +: IDX_W];
    right_b_r       <= split[FRACTION_BITS +: WEIGHT_W];
    last_b_r        <= last_a_r;
    dep_r.last      <= last_b_r;
    dep_r.left_idx  <= idx_b_r;
    dep_r.right_idx <= idx_b_r + IDX_W'(1);
    dep_r.left_amt  <= deposit_weight - right_b_r;
    dep_r.right_amt <= right_b_r;
  end

  assign dep = dep_r;

endmodule

FILE: rtl/core/ccd_cell.sv
module ccd_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  ccd_pkg::idx_t  cell_idx,
  input  ccd_pkg::dep_t  dep,
  input  logic           shift_en,
  input  ccd_pkg::dens_t shift_in,
  output ccd_pkg::dens_t dens
);
  import ccd_pkg::*;

  dens_t               dens_r, dens_nxt;
  logic [WEIGHT_W-1:0] amt;
  logic [DENS_W:0]     sum;

  always_comb begin
    amt = '0;
    if (dep.left_idx == cell_idx) begin
      amt = dep.left_amt;
    end else if (dep.right_idx == cell_idx) begin
      amt = dep.right_amt;
    end
    sum = {1'b0, dens_r} + (DENS_W + 1)'(amt);
    dens_nxt = dens_r;
    if (shift_en) begin
      dens_nxt = shift_in;
    end else if (dep.vld) begin
      dens_nxt = sum[DENS_W] ? {DENS_W{1'b1}} : sum[DENS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dens_r <= '0;
    end else begin
      dens_r <= dens_nxt;
    end
  end

  assign dens = dens_r;

endmodule

FILE: rtl/core/cic_charge_deposit.sv
// cloud-in-cell charge deposition onto a periodic grid of GRID_POINTS cells.
// each position (signed q16.16) is scaled by cell_scale, the floored cell
// index wraps round the grid, and deposit_weight is split by the truncated
// fraction between that cell and its right neighbor (which wraps to cell 0),
// each part added into a saturating 48-bit density cell. particles are taken
// one per cycle through a three-stage pipeline (multiply, weight split,
// deposit register) whose last stage broadcasts to a row of cells, one cell
// per grid point, each with its own adder. a transaction with tlast closes
// the frame: input is then held off, the pipeline drains and the row shifts
// toward cell 0 once per output transaction, so the readout is GRID_POINTS
// output transactions, at best one per cycle, while zeros shift in at the far
// end and clear the store. the user must write configuration only while no
// frame is in flight; the block itself does not enforce it.
module cic_charge_deposit (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write port
  input  logic                              cfg_wr_en,
  input  logic [ccd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ccd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // particle stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ccd_pkg::POS_W-1:0]         in_tdata,   // position
  input  logic                              in_tlast,   // last_particle
  // density readout stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ccd_pkg::OUT_DATA_W-1:0]    out_tdata,  // grid_index, density, zero pad
  output logic                              out_tlast   // last_entry
);
  import ccd_pkg::*;

  // config registers
  logic [SCALE_W-1:0]  cell_scale_r;
  logic [WEIGHT_W-1:0] deposit_weight_r;

  // frame control
  logic  pending_r;   // frame closed, waiting for readout to finish
  logic  reading_r;   // readout in progress
  idx_t  rd_cnt_r;
  logic  in_acc, out_acc, rd_last;

  dep_t  dep;
  dens_t cell_dens [GRID_POINTS];

  assign in_tready = !pending_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign rd_last   = rd_cnt_r == IDX_W'(GRID_POINTS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_scale_r     <= CELL_SCALE_RST;
      deposit_weight_r <= DEPOSIT_WEIGHT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_CELL_SCALE:     cell_scale_r     <= cfg_wdata[SCALE_W-1:0];
        CFG_DEPOSIT_WEIGHT: deposit_weight_r <= cfg_wdata[WEIGHT_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // a frame closes on tlast, readout starts once that particle is deposited
  // the readout counter wraps back to zero after the last grid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      reading_r <= 1'b0;
      rd_cnt_r  <= '0;
    end else begin
      if (in_acc && in_tlast) begin
        pending_r <= 1'b1;
      end
      if (dep.vld && dep.last) begin
        reading_r <= 1'b1;
      end
      if (out_acc) begin
        rd_cnt_r <= rd_cnt_r + IDX_W'(1);
        if (rd_last) begin
          reading_r <= 1'b0;
          pending_r <= 1'b0;
        end
      end
    end
  end

  ccd_scale u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_vld         (in_acc),
    .in_pos         (in_tdata),
    .in_last        (in_tlast),
    .cell_scale     (cell_scale_r),
    .deposit_weight (deposit_weight_r),
    .dep            (dep)
  );

  // row of cells, shifting toward cell 0 on each readout transaction
  for (genvar i = 0; i < GRID_POINTS; i++) begin : g_cell
    dens_t nbr;
    if (i == GRID_POINTS - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_dens[i+1];
    end
    ccd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .dep      (dep),
      .shift_en (out_acc),
      .shift_in (nbr),
      .dens     (cell_dens[i])
    );
  end

  assign out_tvalid = reading_r;
  assign out_tlast  = rd_last;
  assign out_tdata  = OUT_DATA_W'({cell_dens[0], rd_cnt_r});

endmodule

FILE: rtl/core/ccd_checker.sv
`include "assert_macros.svh"

module ccd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ccd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);
  import ccd_pkg::*;

  // no particle taken while the grid is read out
  `CCD_ASSERT(a_no_input_in_readout, out_tvalid |-> !in_tready)
  // a stalled readout entry holds
  `CCD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // readout run does not break before its last entry
  `CCD_ASSERT(a_run_continues, out_tvalid && out_tready && !out_tlast |=> out_tvalid)
  // grid index steps by one through the run
  `CCD_ASSERT(a_index_step, out_tvalid && out_tready && !out_tlast |=> out_tdata[IDX_W-1:0] == $past(out_tdata[IDX_W-1:0]) + IDX_W'(1))
  // nothing is offered right after reset
  `CCD_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_tvalid)

endmodule

bind cic_charge_deposit ccd_checker u_ccd_checker (.*);

FILE: dv/tb_cic_charge_deposit.sv
`default_nettype none

module tb_cic_charge_deposit;
  timeunit 1ns;
  timeprecision 1ps;

  import ccd_pkg::*;

  // cycle limit: several times the slowest correct run, even with every
  // particle closing a frame under the longest receiver stalls
  localparam int CYCLE_LIMIT   = 200000;
  // long receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES   = 400;
  // settle time after the last readout transaction before touching registers
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_PCT      = 28;
  localparam int RANDOM_ITEMS  = 100;
  // full-weight particles stacked on one cell with no idling on either side
  localparam int FULL_RUN_PARTICLES = 24;

  // register indexes past the two real ones, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = CFG_IDX_W'(3);

  localparam logic [DENS_W-1:0] DENS_MAX = {DENS_W{1'b1}};

  typedef struct {
    idx_t  grid_index;
    dens_t density;
    logic  last_entry;
  } grid_entry_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // dut ports, every input known from time zero
  logic                    cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata  = '0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [POS_W-1:0]        in_tdata   = '0;   // position
  logic                    in_tlast   = 1'b0; // last_particle
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;         // grid_index, density, zero pad
  logic                    out_tlast;         // last_entry

  cic_charge_deposit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // mirror of the density store and the two registers
  // ---------------------------------------------------------------------------
  dens_t               density_mirror [GRID_POINTS];
  logic [SCALE_W-1:0]  scale_mirror  = CELL_SCALE_RST;
  logic [WEIGHT_W-1:0] weight_mirror = DEPOSIT_WEIGHT_RST;

  // densities still owed by the block, oldest first
  grid_entry_t readout_q[$];

  int mismatch_count = 0;
  int cycle_count    = 0;

  // idling controls, owned by the test sequence
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_asked = 0;

  initial begin
    for (int i = 0; i < GRID_POINTS; i++) density_mirror[i] = '0;
  end

  function automatic void add_saturating(input int cell_no, input logic [WEIGHT_W-1:0] amount);
    logic [DENS_W:0] sum;
    sum = {1'b0, density_mirror[cell_no]} + (DENS_W+1)'(amount);
    density_mirror[cell_no] = sum[DENS_W] ? DENS_MAX : sum[DENS_W-1:0];
  endfunction

  // cloud-in-cell split of one particle between its cell and the right neighbor
  function automatic void deposit_particle(input logic [POS_W-1:0] pos);
    logic signed [63:0]       prod;
    longint                   cell_floor;
    longint                   left_cell;
    int                       right_cell;
    logic [FRACTION_BITS-1:0] frac;
    logic [SPLIT_W-1:0]       split;
    logic [WEIGHT_W-1:0]      right_part;
    logic [WEIGHT_W-1:0]      left_part;
    prod       = {{(64-POS_W){pos[POS_W-1]}}, pos};
    prod       = prod * $signed({{(64-SCALE_W){1'b0}}, scale_mirror});
    cell_floor = prod >>> 32;
    // floor toward minus infinity, then a non-negative remainder
    left_cell  = cell_floor % GRID_POINTS;
    if (left_cell < 0) left_cell = left_cell + GRID_POINTS;
    // right neighbor past the end wraps round to cell 0
    right_cell = (left_cell == GRID_POINTS - 1) ? 0 : int'(left_cell) + 1;
    frac       = prod[31 -: FRACTION_BITS];
    split      = SPLIT_W'(weight_mirror) * SPLIT_W'(frac);
    right_part = split[SPLIT_W-1:FRACTION_BITS];
    left_part  = weight_mirror - right_part;
    add_saturating(int'(left_cell), left_part);
    add_saturating(right_cell, right_part);
  endfunction

  // the last particle of a frame owes the whole grid, then the store clears
  function automatic void close_frame();
    grid_entry_t entry;
    for (int i = 0; i < GRID_POINTS; i++) begin
      entry.grid_index = idx_t'(i);
      entry.density    = density_mirror[i];
      entry.last_entry = (i == GRID_POINTS - 1);
      readout_q.push_back(entry);
      density_mirror[i] = '0;
    end
  endfunction

  function automatic void mirror_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CELL_SCALE:     scale_mirror  = data[SCALE_W-1:0];
      CFG_DEPOSIT_WEIGHT: weight_mirror = data[WEIGHT_W-1:0];
      default: ;  // out-of-range index, write is dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // readout side: receiver ready with idling and a long hold-off on request
  // ---------------------------------------------------------------------------
  int hold_taken = 0;
  int hold_left  = 0;

  always @(posedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken <= hold_asked;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_idle_on) begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // compare every readout transaction with the oldest owed grid entry
  always @(posedge clk) begin
    grid_entry_t want;
    idx_t        got_index;
    dens_t       got_density;
    if (rst_n && out_tvalid && out_tready) begin
      got_index   = out_tdata[IDX_W-1:0];
      got_density = out_tdata[IDX_W +: DENS_W];
      if (readout_q.size() == 0) begin
        $error("unexpected readout transaction: grid_index %0d density 0x%012h",
               got_index, got_density);
        mismatch_count++;
      end else begin
        want = readout_q.pop_front();
        if (got_index !== want.grid_index) begin
          $error("grid_index mismatch: expected %0d actual %0d", want.grid_index, got_index);
          mismatch_count++;
        end
        if (got_density !== want.density) begin
          $error("density mismatch at cell %0d: expected 0x%012h actual 0x%012h",
                 want.grid_index, want.density, got_density);
          mismatch_count++;
        end
        if (out_tlast !== want.last_entry) begin
          $error("last_entry mismatch at cell %0d: expected %0b actual %0b",
                 want.grid_index, want.last_entry, out_tlast);
          mismatch_count++;
        end
        if (out_tdata[OUT_DATA_W-1:OUT_FIELDS_W] !== '0) begin
          $error("tdata pad mismatch at cell %0d: expected 0 actual 0x%0h",
                 want.grid_index, out_tdata[OUT_DATA_W-1:OUT_FIELDS_W]);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // particle side
  // ---------------------------------------------------------------------------

  // offer one particle, idling first at random; valid is left high on return
  // so back-to-back transactions never see valid dropped within a step
  task automatic send_particle(input logic [POS_W-1:0] pos, input logic last);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tlast  <= $urandom_range(1);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pos;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    deposit_particle(pos);
    if (last) close_frame();
  endtask

  // sender pauses until the block has returned every owed grid entry
  task automatic wait_readout_done();
    in_tvalid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    mirror_register(idx, data);
  endtask

  // reprogram both registers while idle, with a stray write to an unused index
  task automatic program_regs(input logic [SCALE_W-1:0] scale, input logic [WEIGHT_W-1:0] weight);
    logic [CFG_IDX_W-1:0] stray_idx;
    bit                   stray_first;
    wait_readout_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    stray_idx   = $urandom_range(1) ? CFG_UNUSED_HI : CFG_UNUSED_LO;
    stray_first = $urandom_range(1);
    if (stray_first) write_reg(stray_idx, $urandom);
    // bits above the scale width carry random junk
    write_reg(CFG_CELL_SCALE, {8'($urandom), scale});
    write_reg(CFG_DEPOSIT_WEIGHT, weight);
    if (!stray_first) write_reg(stray_idx, $urandom);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    logic [POS_W-1:0] pos;
    case ($urandom_range(3))
      0: pos = $urandom;
      // within a few grids either side of zero
      1: pos = POS_W'($urandom_range(0, 200 << 16)) - POS_W'(100 << 16);
      // close to a cell boundary
      2: begin
        pos = POS_W'($urandom_range(0, 160)) - POS_W'(80);
        pos = (pos << 16) + POS_W'($urandom_range(0, 2) == 0 ? 16'hFFFF : $urandom_range(0, 1));
      end
      default: begin
        case ($urandom_range(3))
          0: pos = 32'h7FFF_FFFF;
          1: pos = 32'h8000_0000;
          2: pos = 32'hFFFF_FFFF;
          default: pos = 32'h0000_0000;
        endcase
      end
    endcase
    return pos;
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(5))
      0: return SCALE_W'(1);
      1: return {SCALE_W{1'b1}};
      2: return CELL_SCALE_RST;
      3: return SCALE_W'($urandom_range(1, 24'h04_0000));
      default: return SCALE_W'($urandom_range(1, {SCALE_W{1'b1}}));
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(4))
      0: return '0;
      1: return {WEIGHT_W{1'b1}};
      default: return $urandom;
    endcase
  endfunction

  // n particles with random positions, the last one closing the frame
  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) send_particle(pick_position(), i == n - 1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values of both registers: unit scale and unit weight
  task automatic test_reset_settings();
    send_particle(32'h0000_0000, 1'b0);  // exactly on cell 0
    send_particle(32'h0000_8000, 1'b0);  // halfway between 0 and 1
    send_particle(32'h003F_8000, 1'b0);  // right neighbor of the end cell wraps
    send_particle(32'hFFFF_8000, 1'b0);  // negative, floors to the end cell
    send_particle(32'hFFFF_FFFF, 1'b0);  // tiny negative, fraction near one
    send_particle(32'h7FFF_FFFF, 1'b0);
    send_particle(32'h8000_0000, 1'b1);
    // a frame of a single particle
    send_particle(32'h0012_3456, 1'b1);
  endtask

  // register extremes, zero weight and zero scale
  task automatic test_extreme_settings();
    program_regs({SCALE_W{1'b1}}, {WEIGHT_W{1'b1}});
    send_particle(32'h7FFF_FFFF, 1'b0);
    send_particle(32'h8000_0000, 1'b0);
    send_particle(32'h0000_0001, 1'b0);
    send_particle(32'hFFFF_FFFF, 1'b0);
    send_particle(32'h1234_5678, 1'b1);
    program_regs(SCALE_W'(1), '0);
    send_particle(32'h7FFF_FFFF, 1'b0);
    send_particle(32'hA5A5_5A5A, 1'b1);
    // zero scale puts every particle on cell 0 with no fraction
    program_regs('0, $urandom);
    send_particle(32'hDEAD_BEEF, 1'b0);
    send_particle(32'h0000_0000, 1'b1);
  endtask

  // back-to-back full-weight particles on one cell, no idling on either side
  task automatic test_full_weight_run();
    program_regs(CELL_SCALE_RST, {WEIGHT_W{1'b1}});
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < FULL_RUN_PARTICLES; i++) begin
      send_particle(32'h0005_0000, i == FULL_RUN_PARTICLES - 1);
    end
    wait_readout_done();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver holds off while frames keep coming, so the input stalls
  task automatic test_output_backpressure();
    program_regs(pick_scale(), pick_weight());
    hold_asked++;
    send_frame($urandom_range(4, 10));
    send_frame($urandom_range(4, 10));
    send_frame($urandom_range(1, 6));
    wait_readout_done();
  endtask

  // random frames across several register settings
  task automatic test_random_frames();
    int sent;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      program_regs(pick_scale(), pick_weight());
      repeat ($urandom_range(2, 5)) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 10);
        send_frame(n);
        sent += n;
        // now and then the sender waits for the whole readout
        if ($urandom_range(2) == 0) wait_readout_done();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_extreme_settings();
    test_full_weight_run();
    test_output_backpressure();
    test_random_frames();

    wait_readout_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
